// ===== hw/rtl/hdlc_bit_stuffing_serializer_defines.svh =====
// Assertion macros used by the HDLC bit-stuffing serializer back end.
`ifndef HDLC_BIT_STUFFING_SERIALIZER_DEFINES_SVH
`define HDLC_BIT_STUFFING_SERIALIZER_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define HBS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hbs_pkg.sv =====
// Shared types and constants for the HDLC bit-stuffing serializer.
package hbs_pkg;

    // Input kind codes on the item channel
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Decoded operation held in the queue
    typedef enum logic [1:0] {
        OP_DATA,
        OP_START,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    // Flag levels, bit i is sent i-th
    localparam logic [7:0] FLAG_PATTERN    = 8'b0111_1110;
    localparam logic [2:0] STUFF_LIMIT     = 3'd5;
    localparam logic [5:0] RUN_MAX         = 6'd63;
    localparam logic [5:0] ABORT_RUN_RESET = 6'd15;
    localparam int         FIFO_DEPTH      = 2;

endpackage

// ===== hw/rtl/hbs_front.sv =====
// Input stage: takes item transfers, decodes the kind and drops unused codes.
module hbs_front
    import hbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        push_valid,
    output item_t       push_item,
    input  logic        push_ready
);

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    item_t f_item_next;
    logic  take;
    logic  keep;
    op_t   dec_op;

    // Hold off only when a decoded item cannot move on
    assign in_stall   = f_valid_reg && !push_ready;
    assign take       = in_valid && !in_stall;
    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

    // Kind decode; the unused code is accepted and dropped
    always_comb
    begin
        keep   = 1'b1;
        dec_op = OP_DATA;
        case (kind)
            KIND_DATA:  dec_op = OP_DATA;
            KIND_START: dec_op = OP_START;
            KIND_END:   dec_op = OP_END;
            default:    keep   = 1'b0;
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (take)
        begin
            f_valid_next = keep;
            f_item_next  = '{op: dec_op, data: data_byte};
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg <= f_item_next;
    end

endmodule

// ===== hw/rtl/hbs_fifo.sv =====
// Short item queue between the decode stage and the serializer.
module hbs_fifo
    import hbs_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  head_valid,
    output item_t head_item,
    input  logic  pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/hbs_back.sv =====
// Serializer: flags, bit stuffing, abort; one bit per unstalled cycle
module hbs_back
    import hbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [5:0] abort_run,
    input  logic       head_valid,
    input  item_t      head_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_level,
    output logic       is_flag,
    output logic       is_stuffed,
    output logic       status,
    output logic       last
);

`include "hdlc_bit_stuffing_serializer_defines.svh"

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [2:0] stuff_run_reg;
    logic [2:0] stuff_run_next;
    logic [5:0] ones_reg;
    logic [5:0] ones_next;
    logic       aborted_reg;
    logic       aborted_next;
    logic       pending_reg;
    logic       pending_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       level_reg;
    logic       flag_reg;
    logic       stuffed_reg;
    logic       status_reg;
    logic       last_reg;

    logic       emit_ok;
    logic       emit;
    logic       e_level;
    logic       e_flag;
    logic       e_stuffed;
    logic       e_status;
    logic       e_last;
    logic       cur_bit;
    logic [2:0] sr_inc;
    logic [5:0] ones_inc;
    logic       end_of_item;

    assign emit_ok  = !out_valid_reg || !out_stall;
    assign cur_bit  = head_item.data[pos_reg];
    assign sr_inc   = stuff_run_reg + 1'b1;
    assign ones_inc = (ones_reg == RUN_MAX) ? RUN_MAX : ones_reg + 1'b1;

    // Bit generation for the item at the queue head
    always_comb
    begin
        pos_next       = pos_reg;
        stuff_run_next = stuff_run_reg;
        ones_next      = ones_reg;
        aborted_next   = aborted_reg;
        pending_next   = pending_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        e_level        = 1'b0;
        e_flag         = 1'b0;
        e_stuffed      = 1'b0;
        e_status       = 1'b0;
        e_last         = 1'b0;
        end_of_item    = 1'b0;
        if (head_valid)
        begin
            if (head_item.op != OP_START && aborted_reg)
            begin
                // aborted frame: data and end give nothing
                pop = 1'b1;
            end
            else if (emit_ok)
            begin
                emit = 1'b1;
                if (head_item.op != OP_DATA)
                begin
                    e_level = FLAG_PATTERN[pos_reg];
                    e_flag  = 1'b1;
                    if (pos_reg == 3'd7)
                    begin
                        end_of_item    = 1'b1;
                        stuff_run_next = '0;
                        ones_next      = '0;
                        if (head_item.op == OP_START)
                        begin
                            aborted_next = 1'b0;
                        end
                    end
                end
                else if (pending_reg)
                begin
                    // inserted zero; abort check of the preceding one
                    e_stuffed    = 1'b1;
                    pending_next = 1'b0;
                    if (ones_reg >= abort_run)
                    begin
                        e_status     = 1'b1;
                        end_of_item  = 1'b1;
                        aborted_next = 1'b1;
                    end
                    else if (pos_reg == 3'd7)
                    begin
                        end_of_item = 1'b1;
                    end
                end
                else
                begin
                    e_level = cur_bit;
                    if (cur_bit)
                    begin
                        ones_next = ones_inc;
                        if (sr_inc >= STUFF_LIMIT)
                        begin
                            // zero goes out as the next line bit, run restarts
                            pending_next   = 1'b1;
                            stuff_run_next = '0;
                        end
                        else
                        begin
                            stuff_run_next = sr_inc;
                            if (ones_inc >= abort_run)
                            begin
                                e_status     = 1'b1;
                                end_of_item  = 1'b1;
                                aborted_next = 1'b1;
                            end
                            else if (pos_reg == 3'd7)
                            begin
                                end_of_item = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        stuff_run_next = '0;
                        ones_next      = '0;
                        if (pos_reg == 3'd7)
                        begin
                            end_of_item = 1'b1;
                        end
                    end
                end

                e_last = end_of_item;
                if (end_of_item)
                begin
                    pop      = 1'b1;
                    pos_next = '0;
                end
                else if (!pending_next)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            stuff_run_reg <= '0;
            ones_reg      <= '0;
            aborted_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            stuff_run_reg <= stuff_run_next;
            ones_reg      <= ones_next;
            aborted_reg   <= aborted_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            level_reg   <= e_level;
            flag_reg    <= e_flag;
            stuffed_reg <= e_stuffed;
            status_reg  <= e_status;
            last_reg    <= e_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = level_reg;
    assign is_flag    = flag_reg;
    assign is_stuffed = stuffed_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // Checks
    `HBS_ASSERT_ALWAYS(a_stuff_run_range, stuff_run_reg < STUFF_LIMIT, "stuff run overflow")
    `HBS_ASSERT_ALWAYS(a_stuffed_is_zero, !(out_valid_reg && stuffed_reg && level_reg), "stuffed one")
    `HBS_ASSERT_ALWAYS(a_status_ends_item, !(out_valid_reg && status_reg && !last_reg), "abort not last")
    `HBS_ASSERT_NEXT(a_pending_stuff, pending_reg, out_valid_reg || pending_reg, "stuff lost")
    `HBS_ASSERT_ALWAYS(a_pending_data, !pending_reg || (head_valid && head_item.op == OP_DATA), "stuff no data")

endmodule

// ===== hw/rtl/hdlc_bit_stuffing_serializer.sv =====
// Path: input register, queue, output register. Throughput: one line bit per cycle while
// the queue has an item and out_stall is low; a flag gives 8 bits, a data byte 8 plus one
// per stuffed zero (up to 10, fewer when it aborts), a data or end item in an aborted frame
// none; an unused kind is dropped at the input and costs no bit time.
// Reset: abort_run returns to 15, runs and the abort mark clear, queue empties.
// Configuration writes are taken in every cycle.
module hdlc_bit_stuffing_serializer
    import hbs_pkg::*;
#(
    parameter int FIFO_DEPTH_P = FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_level,
    output logic       is_flag,
    output logic       is_stuffed,
    output logic       status,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

    logic [5:0] abort_run_reg;
    logic [5:0] abort_run_next;
    logic       push_valid;
    item_t      push_item;
    logic       push_ready;
    logic       head_valid;
    item_t      head_item;
    logic       pop;

    // Abort run register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        abort_run_next = abort_run_reg;
        if (cfg_valid && cfg_ready)
        begin
            abort_run_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_run_reg <= ABORT_RUN_RESET;
        end
        else
        begin
            abort_run_reg <= abort_run_next;
        end
    end

    hbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    hbs_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    hbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .abort_run  (abort_run_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_level (line_level),
        .is_flag    (is_flag),
        .is_stuffed (is_stuffed),
        .status     (status),
        .last       (last)
    );

endmodule

// ===== verif/hdlc_bit_stuffing_serializer_checker.sv =====
// Checker for the HDLC serializer: predicts line bits per accepted item and compares them.
module hdlc_bit_stuffing_serializer_checker
    import hbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       line_level,
    input  logic       is_flag,
    input  logic       is_stuffed,
    input  logic       status,
    input  logic       last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [5:0] cfg_data,
    output int         failures,
    output int         pending,
    output int         bits_checked,
    output int         aborts_seen
);

    typedef struct packed {
        logic level;
        logic flag;
        logic stuffed;
        logic status;
        logic last;
    } line_bit_t;

    line_bit_t  expected_line_bits [$];

    // Shadow copy of the serializer state
    logic [5:0] abort_limit;
    logic [2:0] stuff_run;
    logic [5:0] ones_run;
    logic       frame_aborted;

    int fail_count;
    int checked_count;
    int abort_count;

    // Only the first ten failures are printed
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", what);
    endtask

    // Line bits that one item gives, queued in send order
    task automatic predict_line_bits(input logic [1:0] k, input logic [7:0] b);
        line_bit_t bits [10];
        int        n;
        logic      stop;
        n    = 0;
        stop = 1'b0;
        if (k == KIND_START || (k == KIND_END && !frame_aborted))
        begin
            if (k == KIND_START)
                frame_aborted = 1'b0;
            stuff_run = '0;
            ones_run  = '0;
            for (int i = 0; i < 8; i++)
            begin
                bits[n] = '{FLAG_PATTERN[i], 1'b1, 1'b0, 1'b0, 1'b0};
                n++;
            end
        end
        else if (k == KIND_DATA && !frame_aborted)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (!stop)
                begin
                    bits[n] = '{b[i], 1'b0, 1'b0, 1'b0, 1'b0};
                    n++;
                    if (b[i])
                    begin
                        stuff_run = stuff_run + 3'd1;
                        if (ones_run != RUN_MAX)
                            ones_run = ones_run + 6'd1;
                        // stuffed zero restarts the stuffing count, not the abort run
                        if (stuff_run >= STUFF_LIMIT)
                        begin
                            bits[n]   = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
                            n++;
                            stuff_run = '0;
                        end
                        // abort marks the last bit sent and drops the rest of the byte
                        if (ones_run >= abort_limit)
                        begin
                            bits[n-1].status = 1'b1;
                            frame_aborted    = 1'b1;
                            stop             = 1'b1;
                        end
                    end
                    else
                    begin
                        stuff_run = '0;
                        ones_run  = '0;
                    end
                end
            end
        end
        if (n > 0)
            bits[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_line_bits.push_back(bits[i]);
    endtask

    // Compare output transfers, then track config and input transfers
    always @(posedge clk or negedge rst_n)
    begin
        line_bit_t got;
        line_bit_t want;
        if (!rst_n)
        begin
            abort_limit   = ABORT_RUN_RESET;
            stuff_run     = '0;
            ones_run      = '0;
            frame_aborted = 1'b0;
            expected_line_bits.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{line_level, is_flag, is_stuffed, status, last};
                checked_count++;
                if (expected_line_bits.size() == 0)
                    note_failure($sformatf(
                        "unexpected line bit level/flag/stuffed/status/last %b/%b/%b/%b/%b",
                        got.level, got.flag, got.stuffed, got.status, got.last));
                else
                begin
                    want = expected_line_bits.pop_front();
                    if (want.status)
                        abort_count++;
                    if (got.level !== want.level || got.flag !== want.flag ||
                        got.stuffed !== want.stuffed || got.status !== want.status ||
                        got.last !== want.last)
                        note_failure($sformatf(
                            "line bit %0d level/flag/stuffed/status/last: expected %b/%b/%b/%b/%b, got %b/%b/%b/%b/%b",
                            checked_count, want.level, want.flag, want.stuffed, want.status,
                            want.last, got.level, got.flag, got.stuffed, got.status, got.last));
                end
            end
            if (cfg_valid && cfg_ready)
                abort_limit = cfg_data;
            if (in_valid && !in_stall)
                predict_line_bits(kind, data_byte);
        end
        failures     <= fail_count;
        pending      <= expected_line_bits.size();
        bits_checked <= checked_count;
        aborts_seen  <= abort_count;
    end

endmodule

// ===== verif/hdlc_bit_stuffing_serializer_tb.sv =====
// Testbench top for the HDLC serializer: stimulus, receiver stalls, timeout and verdict.
module hdlc_bit_stuffing_serializer_tb;
    import hbs_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         HOLD_CYCLES     = 250;
    localparam int         ITEMS_PER_PHASE = 125;
    localparam int         SETTLE_CYCLES   = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       line_level;
    logic       is_flag;
    logic       is_stuffed;
    logic       status;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;

    logic       hold_start = 1'b0;
    int         hold_left;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         cycles = 0;
    int         items_sent = 0;
    int         failures;
    int         pending;
    int         bits_checked;
    int         aborts_seen;
    int         limit_b;
    int         limit_c;

    hdlc_bit_stuffing_serializer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_level (line_level),
        .is_flag    (is_flag),
        .is_stuffed (is_stuffed),
        .status     (status),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    hdlc_bit_stuffing_serializer_checker line_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_level   (line_level),
        .is_flag      (is_flag),
        .is_stuffed   (is_stuffed),
        .status       (status),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending),
        .bits_checked (bits_checked),
        .aborts_seen  (aborts_seen)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Long receiver hold-off, counted down here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver stalls
    always @(posedge clk)
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One item transfer, with optional idle cycles before it
    task automatic send_item(input logic [1:0] k, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    // Wait until every predicted line bit has come out, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_abort_run(input logic [5:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Bytes biased toward long ones runs
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 8'hFF;
        else if (r < 35)
            return 8'h00;
        else if (r < 50)
            return 8'hFF ^ (8'h01 << $urandom_range(7));
        else
            return 8'($urandom_range(255));
    endfunction

    // Mostly whole frames with random content, some noise items and missing ends
    task automatic run_random_phase(input int quota);
        int first;
        int n;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_item(KIND_START, 8'($urandom_range(255)));
                n = $urandom_range(1, 6);
                repeat (n) send_item(KIND_DATA, pick_byte());
                if ($urandom_range(9) != 0)
                    send_item(KIND_END, 8'($urandom_range(255)));
            end
            else
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= KIND_DATA;
        data_byte     <= 8'h00;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        send_idle_pct = 26;
        recv_idle_pct <= 63;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default abort limit: data before a frame, stuffing, abort on a
        // stuffed zero, items dropped while aborted, unused kind
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_START, 8'h00);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h55);
        send_item(KIND_END, 8'h00);
        send_item(KIND_UNUSED, 8'hA5);
        send_item(KIND_START, 8'hFF);
        send_item(KIND_DATA, 8'h7E);
        send_item(KIND_DATA, 8'hF8);
        send_item(KIND_DATA, 8'h1F);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_END, 8'hFF);

        // Abort limit zero: first data one aborts, zeros never do
        write_abort_run(6'd0);
        send_item(KIND_START, 8'h00);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_END, 8'h00);

        // Largest abort limit reached by a long ones run
        write_abort_run(6'd63);
        send_item(KIND_START, 8'h00);
        repeat (8) send_item(KIND_DATA, 8'hFF);

        // Random phase: sender idles lightly, receiver heavily
        write_abort_run(6'd6);
        run_random_phase(ITEMS_PER_PHASE);

        // Random phase: roles swapped
        limit_b = $urandom_range(7, 20);
        write_abort_run(6'(limit_b));
        send_idle_pct = 63;
        recv_idle_pct <= 26;
        run_random_phase(ITEMS_PER_PHASE);

        // Random phase without idling, opened by a long receiver hold-off
        limit_c = $urandom_range(6, 63);
        write_abort_run(6'(limit_c));
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        run_random_phase(ITEMS_PER_PHASE);

        wait_drained();
        $display("Sent %0d items: directed frames, then random frames at abort limits 6, %0d, %0d",
                 items_sent, limit_b, limit_c);
        $display("Checked %0d line bits, %0d of them ending an aborted frame",
                 bits_checked, aborts_seen);
        if (failures == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
